@@ rtl/srec_pkg.sv @@
// Shared types, codes and field layout of the S-record line parser.
package srec_pkg;

    // Result kinds, carried on the master-side tuser
    localparam int KIND_W = 2;
    typedef enum logic [KIND_W-1:0] {
        KIND_DATA  = 2'd0,
        KIND_END   = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    // Error codes
    localparam int ERR_W = 2;
    typedef enum logic [ERR_W-1:0] {
        ERR_BAD_START = 2'd0,
        ERR_BAD_TYPE  = 2'd1,
        ERR_SHORT_CNT = 2'd2,
        ERR_TRUNCATED = 2'd3
    } t_err;

    // Field widths
    localparam int CHAR_W = 8;
    localparam int TYPE_W = 4;
    localparam int ADDR_W = 32;
    localparam int BYTE_W = 8;

    // Result tdata layout, lowest bits first
    localparam int TYPE_LSB = 0;
    localparam int ADDR_LSB = TYPE_LSB + TYPE_W;
    localparam int DATA_LSB = ADDR_LSB + ADDR_W;
    localparam int CCHK_LSB = DATA_LSB + BYTE_W;
    localparam int SCHK_LSB = CCHK_LSB + BYTE_W;
    localparam int ECODE_LSB = SCHK_LSB + BYTE_W;
    localparam int RES_BITS = ECODE_LSB + ERR_W;
    localparam int RES_W = ((RES_BITS + 7) / 8) * 8;

    // Characters
    localparam logic [CHAR_W-1:0] CH_S  = 8'h53;
    localparam logic [CHAR_W-1:0] CH_LF = 8'h0A;

endpackage

@@ rtl/srecord_line_parser.sv @@
// S-record line parser: character stream in, data bytes and record summaries out.
//
// The block takes S-record text one character per transaction on the slave
// stream and decodes it in a single registered pass: the parse state and the
// result register are the only storage, so one character is taken every
// clock cycle (its result shows in the next cycle) as long as the master
// side keeps taking results. The result register is refilled in the same
// cycle it is emptied, so a character is accepted whenever the result slot
// is empty or being taken. Each data byte comes out with kind DATA and its
// byte address (record address plus offset, wrapping at 32 bits). After the
// checksum pair a kind END result carries the record address, the ones
// complement of the byte sum over count, address and data, and the stored
// checksum; characters are then dropped up to and including a line feed.
// A bad start character, a bad type digit, a count too short to hold the
// address and checksum, or a line feed inside a record gives one kind ERROR
// result, after which every character is accepted and dropped until reset.
// Non-hex digits decode as zero.
module srecord_line_parser
    import srec_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // slave stream: tdata = character[7:0]
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [CHAR_W-1:0] s_axis_tdata,
    // master stream: tdata = record_type[3:0], address[35:4], data_byte[43:36],
    // computed_checksum[51:44], stored_checksum[59:52], error_code[61:60], zeros
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [RES_W-1:0]  m_axis_tdata,
    // tuser = kind[1:0]
    output logic [KIND_W-1:0] m_axis_tuser
);

    typedef enum logic [3:0] {
        PH_START = 4'd0,
        PH_TYPE  = 4'd1,
        PH_CNT_H = 4'd2,
        PH_CNT_L = 4'd3,
        PH_ADR_H = 4'd4,
        PH_ADR_L = 4'd5,
        PH_DAT_H = 4'd6,
        PH_DAT_L = 4'd7,
        PH_CHK_H = 4'd8,
        PH_CHK_L = 4'd9,
        PH_SKIP  = 4'd10
    } t_phase;

    // Hex digit decode; anything else reads as zero
    function automatic logic [3:0] hex_nibble(input logic [CHAR_W-1:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c[3:0];
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            v = c[3:0] + 4'd9;
        end
        return v;
    endfunction

    // Parse state
    t_phase             r_phase, n_phase;
    logic [3:0]         r_nib_hold, n_nib_hold;
    logic [TYPE_W-1:0]  r_type, n_type;
    logic [7:0]         r_bytes_left, n_bytes_left;
    logic [2:0]         r_adr_left, n_adr_left;
    logic [ADDR_W-1:0]  r_adr_acc, n_adr_acc;
    logic [7:0]         r_sum, n_sum;
    logic [7:0]         r_offset, n_offset;
    logic               r_halted, n_halted;

    // Result register
    logic               r_out_valid;
    t_kind              r_kind, n_kind;
    logic [TYPE_W-1:0]  r_rtype, n_rtype;
    logic [ADDR_W-1:0]  r_addr, n_addr;
    logic [BYTE_W-1:0]  r_data, n_data;
    logic [BYTE_W-1:0]  r_cchk, n_cchk;
    logic [BYTE_W-1:0]  r_schk, n_schk;
    t_err               r_ecode, n_ecode;
    logic               n_load;

    logic               in_accept;
    logic [3:0]         nib;
    logic [7:0]         cur_byte;
    logic [2:0]         alen;

    // Take a character whenever the result slot is free or draining
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign nib      = hex_nibble(s_axis_tdata);
    assign cur_byte = {r_nib_hold, nib};

    // Address length follows the record type
    always_comb begin
        priority if (r_type == 4'd2) begin
            alen = 3'd3;
        end else if (r_type == 4'd3 || r_type == 4'd7) begin
            alen = 3'd4;
        end else begin
            alen = 3'd2;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_nib_hold   = r_nib_hold;
        n_type       = r_type;
        n_bytes_left = r_bytes_left;
        n_adr_left   = r_adr_left;
        n_adr_acc    = r_adr_acc;
        n_sum        = r_sum;
        n_offset     = r_offset;
        n_halted     = r_halted;

        n_load  = 1'b0;
        n_kind  = KIND_ERROR;
        n_rtype = r_type;
        n_addr  = '0;
        n_data  = '0;
        n_cchk  = '0;
        n_schk  = '0;
        n_ecode = ERR_BAD_START;

        if (in_accept && !r_halted) begin
            if (r_phase == PH_SKIP) begin
                // Drop the rest of the line
                if (s_axis_tdata == CH_LF) begin
                    n_phase = PH_START;
                end
            end else if (r_phase == PH_START) begin
                n_type = '0;
                if (s_axis_tdata != CH_S) begin
                    n_load   = 1'b1;
                    n_rtype  = '0;
                    n_ecode  = ERR_BAD_START;
                    n_halted = 1'b1;
                end else begin
                    n_phase = PH_TYPE;
                end
            end else if (s_axis_tdata == CH_LF) begin
                // Line ended inside a record
                n_load   = 1'b1;
                n_ecode  = ERR_TRUNCATED;
                n_halted = 1'b1;
            end else begin
                unique case (r_phase)
                    PH_TYPE: begin
                        n_type  = nib;
                        n_rtype = nib;
                        if (nib == 4'd0 || nib == 4'd1 || nib == 4'd2 ||
                            nib == 4'd3 || nib == 4'd5 || nib == 4'd7) begin
                            n_phase = PH_CNT_H;
                        end else begin
                            n_load   = 1'b1;
                            n_ecode  = ERR_BAD_TYPE;
                            n_halted = 1'b1;
                        end
                    end
                    PH_CNT_L: begin
                        if (cur_byte < {5'd0, alen} + 8'd1) begin
                            n_load   = 1'b1;
                            n_ecode  = ERR_SHORT_CNT;
                            n_halted = 1'b1;
                        end else begin
                            n_bytes_left = cur_byte - {5'd0, alen};
                            n_adr_left   = alen;
                            n_adr_acc    = '0;
                            n_sum        = cur_byte;
                            n_offset     = '0;
                            n_phase      = PH_ADR_H;
                        end
                    end
                    PH_ADR_L: begin
                        n_adr_acc  = {r_adr_acc[ADDR_W-9:0], cur_byte};
                        n_sum      = r_sum + cur_byte;
                        n_adr_left = r_adr_left - 3'd1;
                        if (n_adr_left != 3'd0) begin
                            n_phase = PH_ADR_H;
                        end else if (r_bytes_left <= 8'd1) begin
                            n_phase = PH_CHK_H;
                        end else begin
                            n_phase = PH_DAT_H;
                        end
                    end
                    PH_DAT_L: begin
                        n_sum        = r_sum + cur_byte;
                        n_bytes_left = r_bytes_left - 8'd1;
                        n_offset     = r_offset + 8'd1;
                        n_phase      = (n_bytes_left <= 8'd1) ? PH_CHK_H : PH_DAT_H;
                        n_load       = 1'b1;
                        n_kind       = KIND_DATA;
                        n_addr       = r_adr_acc + {{(ADDR_W-8){1'b0}}, r_offset};
                        n_data       = cur_byte;
                    end
                    PH_CHK_L: begin
                        n_phase = PH_SKIP;
                        n_load  = 1'b1;
                        n_kind  = KIND_END;
                        n_addr  = r_adr_acc;
                        n_cchk  = ~r_sum;
                        n_schk  = cur_byte;
                    end
                    PH_CNT_H, PH_ADR_H, PH_DAT_H, PH_CHK_H: begin
                        // Hold the high nibble, advance to the low one
                        n_nib_hold = nib;
                        n_phase    = t_phase'(r_phase + 4'd1);
                    end
                    default: begin
                        n_phase = PH_START;
                    end
                endcase
            end
        end
    end

    // Parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_START;
            r_nib_hold   <= '0;
            r_type       <= '0;
            r_bytes_left <= '0;
            r_adr_left   <= '0;
            r_adr_acc    <= '0;
            r_sum        <= '0;
            r_offset     <= '0;
            r_halted     <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_nib_hold   <= n_nib_hold;
            r_type       <= n_type;
            r_bytes_left <= n_bytes_left;
            r_adr_left   <= n_adr_left;
            r_adr_acc    <= n_adr_acc;
            r_sum        <= n_sum;
            r_offset     <= n_offset;
            r_halted     <= n_halted;
        end
    end

    // Result valid: set on load, clear once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (n_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload; a load only happens when the slot is free or being taken
    always_ff @(posedge i_clk) begin
        if (n_load) begin
            r_kind  <= n_kind;
            r_rtype <= n_rtype;
            r_addr  <= n_addr;
            r_data  <= n_data;
            r_cchk  <= n_cchk;
            r_schk  <= n_schk;
            r_ecode <= n_ecode;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_kind;
    assign m_axis_tdata  = {{(RES_W-RES_BITS){1'b0}}, r_ecode, r_schk, r_cchk,
                            r_data, r_addr, r_rtype};

endmodule

@@ rtl/srec_checker.sv @@
// Port-level checks of the S-record line parser, bound to its top level.
module srec_checker
    import srec_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic [CHAR_W-1:0] s_axis_tdata,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [RES_W-1:0]  m_axis_tdata,
    input logic [KIND_W-1:0] m_axis_tuser
);

    logic r_err_seen;

    // Mark that an error transaction has gone out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_seen <= 1'b0;
        end else if (m_axis_tvalid && m_axis_tready && m_axis_tuser == KIND_ERROR) begin
            r_err_seen <= 1'b1;
        end
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty result slot");

    a_silent_after_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err_seen |-> !m_axis_tvalid)
        else $error("result after error");

    a_error_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_ERROR |->
            m_axis_tdata[ECODE_LSB-1:ADDR_LSB] == '0)
        else $error("error result carries nonzero payload");

    a_data_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_DATA |->
            (m_axis_tdata[TYPE_W-1:0] == 4'd0 || m_axis_tdata[TYPE_W-1:0] == 4'd1 ||
             m_axis_tdata[TYPE_W-1:0] == 4'd2 || m_axis_tdata[TYPE_W-1:0] == 4'd3 ||
             m_axis_tdata[TYPE_W-1:0] == 4'd5 || m_axis_tdata[TYPE_W-1:0] == 4'd7))
        else $error("data byte from a record of invalid type");

endmodule

bind srecord_line_parser srec_checker u_srec_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
